FILE: rtl/core/ecv_pkg.sv
// shared constants, types and rounding helper for the easing curve evaluator
package ecv_pkg;

  localparam int FRAC_BITS = 16;

  localparam int PHASE_W = 24;
  localparam int OUT_W   = 18;
  localparam int SEL_W   = 4;

  localparam int T_W    = FRAC_BITS + 1;
  localparam int X_W    = FRAC_BITS + 2;
  localparam int COEF_W = FRAC_BITS + 3;
  localparam int SQ_W   = 2 * X_W;
  localparam int LIN_W  = X_W + COEF_W;
  localparam int A_W    = FRAC_BITS + 4;
  localparam int P_W    = X_W + A_W;
  localparam int R_W    = FRAC_BITS + 8;
  localparam int RND_W  = P_W + 1;

  localparam longint ONE_FX  = longint'(64'd1 << FRAC_BITS);
  localparam longint HALF_FX = longint'(64'd1 << (FRAC_BITS - 1));
  localparam longint S1_FX   =
    longint'((64'd170158 * (64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000);
  localparam longint S2_FX   =
    longint'((64'd25949095 * (64'd1 << FRAC_BITS) + 64'd5000000) / 64'd10000000);

  localparam longint OUT_MAX = longint'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam longint OUT_MIN = -longint'(64'd1 << (OUT_W - 1));

  // curve select codes
  localparam logic [SEL_W-1:0] SEL_LINEAR      = 4'd0;
  localparam logic [SEL_W-1:0] SEL_QUAD_IN     = 4'd1;
  localparam logic [SEL_W-1:0] SEL_QUAD_OUT    = 4'd2;
  localparam logic [SEL_W-1:0] SEL_QUAD_INOUT  = 4'd3;
  localparam logic [SEL_W-1:0] SEL_CUBIC_IN    = 4'd4;
  localparam logic [SEL_W-1:0] SEL_CUBIC_OUT   = 4'd5;
  localparam logic [SEL_W-1:0] SEL_CUBIC_INOUT = 4'd6;
  localparam logic [SEL_W-1:0] SEL_BACK_IN     = 4'd7;
  localparam logic [SEL_W-1:0] SEL_BACK_OUT    = 4'd8;
  localparam logic [SEL_W-1:0] SEL_BACK_INOUT  = 4'd9;

  typedef enum logic [1:0] {
    KIND_LIN,
    KIND_QUAD,
    KIND_CUBE,
    KIND_BACK
  } kind_e;

  // rescale shift is FRAC_BITS - 2 + code
  typedef enum logic [1:0] {
    SH_M2,
    SH_M1,
    SH_0,
    SH_P1
  } shift_e;

  typedef struct packed {
    kind_e  kind;
    shift_e sh_sq;
    shift_e sh_fin;
    logic   use_s2;
    logic   off_neg;
    logic   base_one;
    logic   neg;
  } ctl_t;

  typedef struct packed {
    ctl_t                  ctl;
    logic signed [X_W-1:0] x;
  } prep_t;

  typedef struct packed {
    ctl_t                    ctl;
    logic signed [X_W-1:0]   x;
    logic signed [SQ_W-1:0]  sq;
    logic signed [LIN_W-1:0] lin;
  } mul1_t;

  typedef struct packed {
    ctl_t                  ctl;
    logic signed [X_W-1:0] m;
    logic signed [A_W-1:0] a;
    logic signed [X_W-1:0] q;
  } rnd_t;

  typedef struct packed {
    ctl_t                  ctl;
    logic signed [P_W-1:0] p;
    logic signed [X_W-1:0] q;
  } mul2_t;

  // round to nearest, ties toward +infinity, by 2^k
  function automatic logic signed [RND_W-1:0] rnd_shift(input logic signed [RND_W-1:0] p,
                                                        input shift_e sh);
    int k;
    logic signed [RND_W-1:0] half;
    logic signed [RND_W-1:0] sum;
    k = FRAC_BITS - 2 + int'(sh);
    half = '0;
    half[k-1] = 1'b1;
    sum = p + half;
    return sum >>> k;
  endfunction

endpackage

FILE: rtl/core/ecv_if.sv
// handshake channels of the easing curve evaluator
interface ecv_phase_if import ecv_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [PHASE_W-1:0] phase;

  modport source (output valid, output phase, input ready);
  modport sink   (input valid, input phase, output ready);
endinterface

interface ecv_eased_if import ecv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] eased_value;

  modport source (output valid, output eased_value, input ready);
  modport sink   (input valid, input eased_value, output ready);
endinterface

interface ecv_cfg_if import ecv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEL_W-1:0] curve_select;

  modport source (output valid, output curve_select, input ready);
  modport sink   (input valid, input curve_select, output ready);
endinterface

FILE: rtl/core/easing_curve_evaluator.sv
// top level of the easing curve evaluator
// Usage:
//   phase_i  valid/ready channel, one signed Q8.16 phase word per handshake;
//            the value is clamped to 0..1 before the curve is evaluated
//   eased_o  valid/ready channel, one signed Q2.16 eased word per phase word,
//            in the order the phase words were taken
//   cfg_i    valid/ready channel carrying curve_select; always ready, write it
//            only while no word is in flight
// Words pass through clamp/decode, square and slope products, rescale, second
// product, then final rescale with saturation into the output register.
// Throughput is one word per cycle while the receiver holds ready high; each of
// the five stages holds one word.
// Reset empties every stage and sets curve_select to linear.
// When the receiver holds ready low, the output word is held and words move up
// into empty stages behind it, so phase_i stays ready until all five are full.
module easing_curve_evaluator import ecv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ecv_phase_if.sink   phase_i,
  ecv_eased_if.source eased_o,
  ecv_cfg_if.sink     cfg_i
);

  logic [SEL_W-1:0] curve_select_q;
  logic             prep_valid, prep_ready;
  prep_t            prep_data;
  logic             arith_valid, arith_ready;
  mul2_t            arith_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_select_q <= SEL_LINEAR;
    end else if (cfg_i.valid) begin
      curve_select_q <= cfg_i.curve_select;
    end
  end

  ecv_prep u_prep (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .phase_i        (phase_i),
    .curve_select_i (curve_select_q),
    .valid_o        (prep_valid),
    .ready_i        (prep_ready),
    .data_o         (prep_data)
  );

  ecv_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .ready_o (prep_ready),
    .data_i  (prep_data),
    .valid_o (arith_valid),
    .ready_i (arith_ready),
    .data_o  (arith_data)
  );

  ecv_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (arith_valid),
    .ready_o (arith_ready),
    .data_i  (arith_data),
    .eased_o (eased_o)
  );

endmodule

FILE: rtl/core/ecv_prep.sv
// input stage: phase clamp, curve decode and operand selection
module ecv_prep import ecv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  ecv_phase_if.sink        phase_i,
  input  logic [SEL_W-1:0] curve_select_i,
  output logic             valid_o,
  input  logic             ready_i,
  output prep_t            data_o
);

  logic                  valid_q;
  prep_t                 data_d, data_q;
  logic [T_W-1:0]        t;
  logic                  upper;
  logic signed [X_W:0]   tx, one_x;
  logic signed [X_W:0]   x_omt, x_tmo, x_2t, x_2m, x_2tm2;

  assign phase_i.ready = !valid_q || ready_i;
  assign valid_o       = valid_q;
  assign data_o        = data_q;

  // clamp to [0, one]
  always_comb begin
    if (phase_i.phase[PHASE_W-1]) begin
      t = '0;
    end else if (phase_i.phase[PHASE_W-2:0] > (PHASE_W-1)'(ONE_FX)) begin
      t = T_W'(ONE_FX);
    end else begin
      t = phase_i.phase[T_W-1:0];
    end
  end

  assign upper  = (t >= T_W'(HALF_FX));
  assign tx     = signed'({2'b00, t});
  assign one_x  = (X_W+1)'(ONE_FX);
  assign x_omt  = one_x - tx;
  assign x_tmo  = tx - one_x;
  assign x_2t   = tx <<< 1;
  assign x_2m   = (one_x <<< 1) - (tx <<< 1);
  assign x_2tm2 = (tx <<< 1) - (one_x <<< 1);

  always_comb begin
    data_d.ctl.kind     = KIND_LIN;
    data_d.ctl.sh_sq    = SH_0;
    data_d.ctl.sh_fin   = SH_0;
    data_d.ctl.use_s2   = 1'b0;
    data_d.ctl.off_neg  = 1'b0;
    data_d.ctl.base_one = 1'b0;
    data_d.ctl.neg      = 1'b0;
    data_d.x            = X_W'(tx);
    case (curve_select_i)
      SEL_LINEAR: begin
      end
      SEL_QUAD_IN: begin
        data_d.ctl.kind = KIND_QUAD;
      end
      SEL_QUAD_OUT: begin
        data_d.ctl.kind     = KIND_QUAD;
        data_d.x            = X_W'(x_omt);
        data_d.ctl.base_one = 1'b1;
        data_d.ctl.neg      = 1'b1;
      end
      SEL_QUAD_INOUT: begin
        data_d.ctl.kind = KIND_QUAD;
        if (upper) begin
          data_d.x            = X_W'(x_2m);
          data_d.ctl.sh_sq    = SH_P1;
          data_d.ctl.base_one = 1'b1;
          data_d.ctl.neg      = 1'b1;
        end else begin
          data_d.ctl.sh_sq = SH_M1;
        end
      end
      SEL_CUBIC_IN: begin
        data_d.ctl.kind = KIND_CUBE;
      end
      SEL_CUBIC_OUT: begin
        data_d.ctl.kind     = KIND_CUBE;
        data_d.x            = X_W'(x_omt);
        data_d.ctl.base_one = 1'b1;
        data_d.ctl.neg      = 1'b1;
      end
      SEL_CUBIC_INOUT: begin
        data_d.ctl.kind = KIND_CUBE;
        if (upper) begin
          data_d.x            = X_W'(x_2m);
          data_d.ctl.sh_fin   = SH_P1;
          data_d.ctl.base_one = 1'b1;
          data_d.ctl.neg      = 1'b1;
        end else begin
          data_d.ctl.sh_fin = SH_M2;
        end
      end
      SEL_BACK_IN: begin
        data_d.ctl.kind    = KIND_BACK;
        data_d.ctl.off_neg = 1'b1;
      end
      SEL_BACK_OUT: begin
        data_d.ctl.kind     = KIND_BACK;
        data_d.x            = X_W'(x_tmo);
        data_d.ctl.base_one = 1'b1;
      end
      SEL_BACK_INOUT: begin
        data_d.ctl.kind   = KIND_BACK;
        data_d.ctl.use_s2 = 1'b1;
        data_d.ctl.sh_fin = SH_P1;
        if (upper) begin
          data_d.x            = X_W'(x_2tm2);
          data_d.ctl.base_one = 1'b1;
        end else begin
          data_d.x           = X_W'(x_2t);
          data_d.ctl.off_neg = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (phase_i.ready) begin
      valid_q <= phase_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_i.ready && phase_i.valid) begin
      data_q <= data_d;
    end
  end

endmodule

FILE: rtl/core/ecv_arith.sv
// three arithmetic stages: first products, rescale, second product
module ecv_arith import ecv_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  prep_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output mul2_t data_o
);

  localparam logic signed [COEF_W-1:0] S1P1_C = COEF_W'(S1_FX + ONE_FX);
  localparam logic signed [COEF_W-1:0] S2P1_C = COEF_W'(S2_FX + ONE_FX);
  localparam logic signed [A_W-1:0]    S1_A   = A_W'(S1_FX);
  localparam logic signed [A_W-1:0]    S2_A   = A_W'(S2_FX);

  logic  v1_q, v2_q, v3_q;
  logic  rdy1, rdy2, rdy3;
  mul1_t s1_d, s1_q;
  rnd_t  s2_d, s2_q;
  mul2_t s3_d, s3_q;

  logic signed [COEF_W-1:0] coef;
  logic signed [A_W-1:0]    off;
  logic signed [A_W-1:0]    lin_r;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v3_q;
  assign data_o  = s3_q;

  // square and back-curve slope products
  assign coef = data_i.ctl.use_s2 ? S2P1_C : S1P1_C;

  always_comb begin
    s1_d.ctl = data_i.ctl;
    s1_d.x   = data_i.x;
    s1_d.sq  = data_i.x * data_i.x;
    s1_d.lin = coef * data_i.x;
  end

  // rescale products
  always_comb begin
    off   = s1_q.ctl.use_s2 ? S2_A : S1_A;
    lin_r = A_W'(rnd_shift(RND_W'(s1_q.lin), SH_0));
    s2_d.ctl = s1_q.ctl;
    s2_d.m   = X_W'(rnd_shift(RND_W'(s1_q.sq), SH_0));
    if (s1_q.ctl.kind == KIND_QUAD) begin
      s2_d.q = X_W'(rnd_shift(RND_W'(s1_q.sq), s1_q.ctl.sh_sq));
    end else begin
      s2_d.q = s1_q.x;
    end
    if (s1_q.ctl.kind == KIND_CUBE) begin
      s2_d.a = A_W'(s1_q.x);
    end else if (s1_q.ctl.off_neg) begin
      s2_d.a = lin_r - off;
    end else begin
      s2_d.a = lin_r + off;
    end
  end

  always_comb begin
    s3_d.ctl = s2_q.ctl;
    s3_d.p   = s2_q.m * s2_q.a;
    s3_d.q   = s2_q.q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      s1_q <= s1_d;
    end
    if (rdy2 && v1_q) begin
      s2_q <= s2_d;
    end
    if (rdy3 && v2_q) begin
      s3_q <= s3_d;
    end
  end

endmodule

FILE: rtl/core/ecv_finish.sv
// output stage: final rescale for cubic and back curves, offset, saturation and output register
module ecv_finish import ecv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  mul2_t      data_i,
  ecv_eased_if.source eased_o
);

  localparam int S_W = R_W + 1;
  localparam logic signed [S_W-1:0] MAX_S = S_W'(OUT_MAX);
  localparam logic signed [S_W-1:0] MIN_S = S_W'(OUT_MIN);

  logic                    valid_q;
  logic signed [OUT_W-1:0] eased_d, eased_q;
  logic signed [R_W-1:0]   r;
  logic signed [S_W-1:0]   rx, base, sum;

  assign ready_o             = !valid_q || eased_o.ready;
  assign eased_o.valid       = valid_q;
  assign eased_o.eased_value = eased_q;

  always_comb begin
    if (data_i.ctl.kind == KIND_LIN || data_i.ctl.kind == KIND_QUAD) begin
      r = R_W'(data_i.q);
    end else begin
      r = R_W'(rnd_shift(RND_W'(data_i.p), data_i.ctl.sh_fin));
    end
    rx   = S_W'(r);
    base = data_i.ctl.base_one ? S_W'(ONE_FX) : '0;
    sum  = data_i.ctl.neg ? (base - rx) : (base + rx);
    if (sum > MAX_S) begin
      eased_d = OUT_W'(MAX_S);
    end else if (sum < MIN_S) begin
      eased_d = OUT_W'(MIN_S);
    end else begin
      eased_d = OUT_W'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      eased_q <= eased_d;
    end
  end

endmodule
